// ----- rtl/core/mbg_pkg.sv -----
package mbg_pkg;

	localparam int CRD_W = 6;

	localparam logic [1:0] CELL_OPEN = 2'd0;
	localparam logic [1:0] CELL_UNVISITED = 2'd1;
	localparam logic [1:0] CELL_WALL = 2'd2;

	localparam logic [1:0] DIR_PLUS_SECOND = 2'd0;
	localparam logic [1:0] DIR_MINUS_FIRST = 2'd1;
	localparam logic [1:0] DIR_MINUS_SECOND = 2'd2;
	localparam logic [1:0] DIR_PLUS_FIRST = 2'd3;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_DRAW = 2'd1,
		OP_READ = 2'd2,
		OP_EXIT = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_TGT_RD,
		S_TGT_CHK,
		S_CARVE,
		S_PROBE,
		S_PROBE_CHK,
		S_POP,
		S_CELL_RD,
		S_CELL_CHK,
		S_EXIT,
		S_RESP
	} state_t;

endpackage

// ----- rtl/core/mbg_ram.sv -----
module mbg_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 441,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/mbg_probe.sv -----
module mbg_probe import mbg_pkg::*; #(
	parameter int SIDE = 21,
	localparam int AW = $clog2(SIDE * SIDE)
) (
	input  logic [CRD_W-1:0] f,
	input  logic [CRD_W-1:0] s,
	input  logic [1:0]       dir,
	input  logic             step_en,
	output logic             in_area,
	output logic [CRD_W-1:0] tf,
	output logic [CRD_W-1:0] ts,
	output logic [AW-1:0]    addr,
	output logic [AW-1:0]    mid_addr
);

	always_comb begin
		tf = f;
		ts = s;
		in_area = 1'b1;
		if (step_en) begin
			case (dir)
				DIR_PLUS_SECOND: begin
					ts = s + CRD_W'(2);
					in_area = (s <= CRD_W'(SIDE - 4));
				end
				DIR_MINUS_FIRST: begin
					tf = f - CRD_W'(2);
					in_area = (f >= CRD_W'(3));
				end
				DIR_MINUS_SECOND: begin
					ts = s - CRD_W'(2);
					in_area = (s >= CRD_W'(3));
				end
				default: begin
					tf = f + CRD_W'(2);
					in_area = (f <= CRD_W'(SIDE - 4));
				end
			endcase
		end
	end

	assign addr = AW'(tf) * AW'(SIDE) + AW'(ts);

	always_comb begin
		case (dir)
			DIR_PLUS_SECOND: mid_addr = addr - AW'(1);
			DIR_MINUS_FIRST: mid_addr = addr + AW'(SIDE);
			DIR_MINUS_SECOND: mid_addr = addr + AW'(1);
			default: mid_addr = addr - AW'(SIDE);
		endcase
	end

endmodule

// ----- rtl/core/maze_backtracker_generator.sv -----
// Each item yields exactly one result, pulsed on strobe for one cycle; the receiver cannot stall
// it. After reset the grid is rewritten one cell per cycle, with busy high throughout; an init
// item does the same and then gives its result. A read checks that the cell lies inside the grid,
// reads it only if so, and then gives its result; an exit writes the exit cell before its result.
// A draw after generation has finished goes straight to its result. Any other draw skips a target
// outside the inner area or a blocked target, or carves the wall and the target cell, then probes
// the neighbors one at a time through the single grid read port; each popped dead end adds a fresh
// probe of up to four neighbors, and the result follows the last probe. A draw can run long when a
// long dead-end chain unwinds. The return-position stack keeps STACK_DEPTH entries; when full, a
// move still carves but its return position is dropped.
module maze_backtracker_generator import mbg_pkg::*; #(
	parameter int SIDE = 21,
	parameter int STACK_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [1:0] direction,
	input  logic [4:0] cell_first,
	input  logic [4:0] cell_second,
	output logic       strobe,
	output logic       carved,
	output logic [4:0] pos_first,
	output logic [4:0] pos_second,
	output logic [1:0] cell_value,
	output logic       done_res
);

	localparam int CELLS = SIDE * SIDE;
	localparam int AW = $clog2(CELLS);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int SW = 2 * CRD_W;
	localparam logic [AW-1:0] EXIT_ADDR = AW'((SIDE - 1) * SIDE + SIDE - 2);

	state_t state_q, state_nx;

	logic [CRD_W-1:0] wf_q, ws_q;
	logic [DW-1:0] depth_q;
	logic finished_q, carved_q, clr_resp_q;
	logic [1:0] cell_value_q, dir_q, pdir_q;
	logic [4:0] cf_q, cs_q;
	logic [CRD_W-1:0] clr_row_q, clr_col_q;
	logic [AW-1:0] clr_addr_q;

	logic [CRD_W-1:0] pr_f, pr_s, pr_tf, pr_ts;
	logic [1:0] pr_dir;
	logic pr_step, pr_in_area;
	logic [AW-1:0] pr_addr, pr_mid;

	logic g_we;
	logic [AW-1:0] g_waddr, g_raddr;
	logic [1:0] g_wdata, g_rdata, clr_val;
	logic s_we;
	logic [DW-1:0] depth_m1;
	logic [SW-1:0] s_rdata;
	logic dead_end, clr_last, cell_in, cq_in;

	mbg_probe #(.SIDE(SIDE)) u_probe (
		.f(pr_f), .s(pr_s), .dir(pr_dir), .step_en(pr_step),
		.in_area(pr_in_area), .tf(pr_tf), .ts(pr_ts), .addr(pr_addr), .mid_addr(pr_mid)
	);

	mbg_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	mbg_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(depth_q[SAW-1:0]), .wdata({wf_q, ws_q}),
		.raddr(depth_m1[SAW-1:0]), .rdata(s_rdata)
	);

	assign depth_m1 = depth_q - DW'(1);
	assign clr_last = (clr_addr_q == AW'(CELLS - 1));
	assign cell_in = (CRD_W'(cell_first) < CRD_W'(SIDE)) && (CRD_W'(cell_second) < CRD_W'(SIDE));
	assign cq_in = (CRD_W'(cf_q) < CRD_W'(SIDE)) && (CRD_W'(cs_q) < CRD_W'(SIDE));

	always_comb begin
		if (clr_row_q == '0 || clr_col_q == '0 || clr_row_q == CRD_W'(SIDE - 1) ||
				clr_col_q == CRD_W'(SIDE - 1)) begin
			clr_val = CELL_WALL;
		end else if (clr_row_q == CRD_W'(1) && clr_col_q == CRD_W'(1)) begin
			clr_val = CELL_OPEN;
		end else begin
			clr_val = CELL_UNVISITED;
		end
	end

	always_comb begin
		pr_f = wf_q;
		pr_s = ws_q;
		pr_dir = pdir_q;
		pr_step = 1'b1;
		if (state_q == S_CELL_RD) begin
			pr_f = CRD_W'(cf_q);
			pr_s = CRD_W'(cs_q);
			pr_step = 1'b0;
		end else if (state_q == S_TGT_RD || state_q == S_TGT_CHK || state_q == S_CARVE) begin
			pr_dir = dir_q;
		end
	end

	always_comb begin
		dead_end = 1'b0;
		if (state_q == S_PROBE) begin
			dead_end = !pr_in_area && pdir_q == 2'd3;
		end else if (state_q == S_PROBE_CHK) begin
			dead_end = g_rdata != CELL_UNVISITED && pdir_q == 2'd3;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op_t'(opcode))
						OP_INIT: state_nx = S_CLEAR;
						OP_DRAW: state_nx = finished_q ? S_RESP : S_TGT_RD;
						OP_READ: state_nx = S_CELL_RD;
						default: state_nx = S_EXIT;
					endcase
				end
			end
			S_CLEAR: begin
				if (clr_last) begin
					state_nx = clr_resp_q ? S_RESP : S_IDLE;
				end
			end
			S_TGT_RD: state_nx = pr_in_area ? S_TGT_CHK : S_PROBE;
			S_TGT_CHK: state_nx = (g_rdata == CELL_UNVISITED) ? S_CARVE : S_PROBE;
			S_CARVE: state_nx = S_PROBE;
			S_PROBE: begin
				if (pr_in_area) begin
					state_nx = S_PROBE_CHK;
				end else if (dead_end) begin
					state_nx = (depth_q == '0) ? S_RESP : S_POP;
				end
			end
			S_PROBE_CHK: begin
				if (g_rdata == CELL_UNVISITED) begin
					state_nx = S_RESP;
				end else if (dead_end) begin
					state_nx = (depth_q == '0) ? S_RESP : S_POP;
				end else begin
					state_nx = S_PROBE;
				end
			end
			S_POP: state_nx = S_PROBE;
			S_CELL_RD: state_nx = cq_in ? S_CELL_CHK : S_RESP;
			S_CELL_CHK: state_nx = S_RESP;
			S_EXIT: state_nx = S_RESP;
			S_RESP: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		g_we = 1'b0;
		g_waddr = pr_addr;
		g_wdata = CELL_OPEN;
		g_raddr = pr_addr;
		s_we = 1'b0;
		case (state_q)
			S_CLEAR: begin
				g_we = 1'b1;
				g_waddr = clr_addr_q;
				g_wdata = clr_val;
			end
			S_TGT_CHK: begin
				g_we = (g_rdata == CELL_UNVISITED);
				g_waddr = pr_mid;
			end
			S_CARVE: begin
				g_we = 1'b1;
				s_we = (depth_q < DW'(STACK_DEPTH));
			end
			S_EXIT: begin
				g_we = 1'b1;
				g_waddr = EXIT_ADDR;
			end
			default: begin
				g_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			wf_q <= CRD_W'(1);
			ws_q <= CRD_W'(1);
			depth_q <= '0;
			finished_q <= 1'b0;
			clr_resp_q <= 1'b0;
			clr_row_q <= '0;
			clr_col_q <= '0;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE && start && op_t'(opcode) == OP_INIT) begin
				wf_q <= CRD_W'(1);
				ws_q <= CRD_W'(1);
				depth_q <= '0;
				finished_q <= 1'b0;
				clr_resp_q <= 1'b1;
				clr_row_q <= '0;
				clr_col_q <= '0;
				clr_addr_q <= '0;
			end
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_col_q == CRD_W'(SIDE - 1)) begin
					clr_col_q <= '0;
					clr_row_q <= clr_row_q + CRD_W'(1);
				end else begin
					clr_col_q <= clr_col_q + CRD_W'(1);
				end
			end
			if (state_q == S_CARVE) begin
				wf_q <= pr_tf;
				ws_q <= pr_ts;
				if (s_we) begin
					depth_q <= depth_q + DW'(1);
				end
			end
			if (dead_end) begin
				if (depth_q == '0) begin
					finished_q <= 1'b1;
				end else begin
					depth_q <= depth_m1;
				end
			end
			if (state_q == S_POP) begin
				wf_q <= s_rdata[SW-1:CRD_W];
				ws_q <= s_rdata[CRD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			dir_q <= direction;
			cf_q <= cell_first;
			cs_q <= cell_second;
			carved_q <= 1'b0;
			cell_value_q <= (op_t'(opcode) == OP_READ && !cell_in) ? CELL_WALL : CELL_OPEN;
		end
		if (state_q == S_TGT_RD || state_q == S_TGT_CHK || state_q == S_CARVE ||
				state_q == S_POP) begin
			pdir_q <= 2'd0;
		end else if ((state_q == S_PROBE && !pr_in_area) || state_q == S_PROBE_CHK) begin
			pdir_q <= pdir_q + 2'd1;
		end
		if (state_q == S_CARVE) begin
			carved_q <= 1'b1;
		end
		if (state_q == S_CELL_CHK) begin
			cell_value_q <= g_rdata;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = (state_q == S_RESP);
	assign carved = carved_q;
	assign pos_first = 5'(wf_q);
	assign pos_second = 5'(ws_q);
	assign cell_value = cell_value_q;
	assign done_res = finished_q;

endmodule

// ----- rtl/core/mbg_checker.sv -----
module mbg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("Result strobe while idle.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("Accepted item did not raise busy.");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("Result strobe lasted more than one cycle.");

	a_strobe_release: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !busy) else $error("Block stayed busy after its result.");

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe)
);
